// File: rtl/sse_pkg.sv
// Shared types and constants for the sorted set engine.
package sse_pkg;

    localparam int KEY_W        = 64;
    localparam int COUNT_W      = 7;
    localparam int SSE_CAPACITY = 64;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2
    } op_t;

    // Per-cycle commands broadcast to every cell of the row.
    typedef struct packed {
        logic cmp;
        logic ins;
        logic rem;
    } ctl_t;

endpackage

// File: rtl/sse_cell.sv
// One storage cell of the sorted row: holds a key, compares it and shifts with its neighbors.
module sse_cell (
    input  logic                      clk,
    input  sse_pkg::ctl_t             ctl,
    input  logic [sse_pkg::KEY_W-1:0] key,
    input  logic                      occ,
    input  logic                      left_gt,
    input  logic [sse_pkg::KEY_W-1:0] left_val,
    input  logic [sse_pkg::KEY_W-1:0] right_val,
    output logic [sse_pkg::KEY_W-1:0] val,
    output logic                      gt,
    output logic                      eq
);
    import sse_pkg::*;

    logic [KEY_W-1:0] val_reg;
    logic [KEY_W-1:0] val_next;
    logic             gt_reg;
    logic             gt_next;
    logic             eq_reg;
    logic             eq_next;

    always_comb
    begin
        gt_next  = gt_reg;
        eq_next  = eq_reg;
        val_next = val_reg;
        if (ctl.cmp)
        begin
            gt_next = occ && (key > val_reg);
            eq_next = occ && (key == val_reg);
        end
        // Cells that sort before the key stay put; the rest move.
        if (ctl.ins && !gt_reg)
        begin
            val_next = left_gt ? key : left_val;
        end
        else if (ctl.rem && !gt_reg)
        begin
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        gt_reg  <= gt_next;
        eq_reg  <= eq_next;
    end

    assign val = val_reg;
    assign gt  = gt_reg;
    assign eq  = eq_reg;

endmodule

// File: rtl/sorted_set_engine.sv
// Top level of the sorted set engine: request/response control around a row of cells.
//
// Usage: the request channel (req_valid, req_stall, op, value) carries one operation
// and a signed 64-bit key per item; op is insert, remove or lookup, and code 3 is a
// no-op. The response channel (rsp_valid, rsp_stall, ok, full_res, count) returns
// exactly one item per request, in order. ok is set when the key was inserted,
// removed or found; full_res flags an insert of a new key into a full store; count
// is the number of held keys after the operation (low 7 bits).
// One request is in flight at a time: an item passes a compare step, in which every
// cell compares its key against the request, and then an update step that shifts the
// row and updates the count. A new request is taken while an earlier response
// still waits in the output register.
// When rsp_stall holds a response, a finished item waits in the update stage and
// req_stall rises until the output register frees.
// Reset clears the count and the handshake state; the cell contents are not reset
// and are only read below the count.
module sorted_set_engine #(
    parameter int CAPACITY = sse_pkg::SSE_CAPACITY
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic [1:0]                  op,
    input  logic signed [sse_pkg::KEY_W-1:0] value,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output logic                        ok,
    output logic                        full_res,
    output logic [sse_pkg::COUNT_W-1:0] count
);
    import sse_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s2_valid_reg;
    logic              s2_valid_next;
    logic [1:0]        op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    logic              ok_reg;
    logic              full_reg;
    logic [COUNT_W-1:0] count_out_reg;

    logic              req_accept;
    logic              commit;
    logic              hit;
    logic              is_full;
    logic              do_ins;
    logic              do_rem;
    logic              res_ok;
    logic              res_full;
    ctl_t              ctl;

    logic [KEY_W-1:0]  cell_val [CAPACITY];
    logic [CAPACITY-1:0] cell_gt;
    logic [CAPACITY-1:0] cell_eq;
    logic [CAPACITY-1:0] cell_occ;

    // The update stage may retire only when the output register is free.
    assign commit     = s2_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall  = s1_valid_reg || (s2_valid_reg && !commit);
    assign req_accept = req_valid && !req_stall;

    assign hit     = |cell_eq;
    assign is_full = (count_reg == CNT_W'(CAPACITY));
    assign do_ins  = commit && (op_reg == OP_INSERT) && !hit && !is_full;
    assign do_rem  = commit && (op_reg == OP_REMOVE) && hit;
    assign res_ok  = ((op_reg == OP_INSERT) && !hit && !is_full)
                  || ((op_reg == OP_REMOVE) && hit)
                  || ((op_reg == OP_LOOKUP) && hit);
    assign res_full = (op_reg == OP_INSERT) && !hit && is_full;

    assign ctl.cmp = s1_valid_reg;
    assign ctl.ins = do_ins;
    assign ctl.rem = do_rem;

    always_comb
    begin
        s1_valid_next  = req_accept;
        s2_valid_next  = s1_valid_reg || (s2_valid_reg && !commit);
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        if (do_ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rem)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        if (commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Keys are held with the sign bit flipped so an unsigned compare gives signed order.
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            op_reg  <= op;
            key_reg <= {~value[KEY_W-1], value[KEY_W-2:0]};
        end
        if (commit)
        begin
            ok_reg        <= res_ok;
            full_reg      <= res_full;
            count_out_reg <= COUNT_W'(count_next);
        end
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic             left_gt;
            logic [KEY_W-1:0] left_val;
            logic [KEY_W-1:0] right_val;

            assign cell_occ[i] = (CNT_W'(i) < count_reg);

            if (i == 0)
            begin : g_first
                assign left_gt  = 1'b1;
                assign left_val = key_reg;
            end
            else
            begin : g_inner
                assign left_gt  = cell_gt[i-1];
                assign left_val = cell_val[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign right_val = cell_val[i];
            end
            else
            begin : g_next
                assign right_val = cell_val[i+1];
            end

            sse_cell u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .key       (key_reg),
                .occ       (cell_occ[i]),
                .left_gt   (left_gt),
                .left_val  (left_val),
                .right_val (right_val),
                .val       (cell_val[i]),
                .gt        (cell_gt[i]),
                .eq        (cell_eq[i])
            );
        end
    endgenerate

    assign rsp_valid = rsp_valid_reg;
    assign ok        = ok_reg;
    assign full_res  = full_reg;
    assign count     = count_out_reg;

    // Only one item travels through the compare and update stages at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_valid_reg && s2_valid_reg))
        else $error("two items in flight");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count exceeds capacity");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_ins |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the count");

    a_commit_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> rsp_valid)
        else $error("retired item produced no response");

endmodule

// File: dv/tb.sv
// Self-checking testbench for the sorted set engine: directed table, then random traffic.
`timescale 1ns / 1ps

module tb;
    import sse_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int POOL_SIZE = 96;
    localparam int SEG_ITEMS = 130;
    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

    typedef struct packed {
        logic               ok;
        logic               full;
        logic [COUNT_W-1:0] cnt;
    } set_result_t;

    typedef struct packed {
        logic [1:0]         code;
        logic [KEY_W-1:0]   key;
        logic               typed;
        set_result_t        res;
    } stim_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      req_valid = 1'b0;
    logic                      req_stall;
    logic [1:0]                op = OP_LOOKUP;
    logic signed [KEY_W-1:0]   value = '0;
    logic                      rsp_valid;
    logic                      rsp_stall = 1'b0;
    logic                      ok;
    logic                      full_res;
    logic [COUNT_W-1:0]        count;

    // Model of the store: held keys in ascending signed order.
    logic signed [KEY_W-1:0]   held_keys[$];
    set_result_t               pending_results[$];
    stim_row_t                 dir_rows[$];
    logic signed [KEY_W-1:0]   key_pool[POOL_SIZE];
    set_result_t               want;
    int                        error_count = 0;
    int                        cycles = 0;
    int                        idle_pct = 0;
    int                        stall_pct = 0;

    sorted_set_engine uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .op        (op),
        .value     (value),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .ok        (ok),
        .full_res  (full_res),
        .count     (count)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
                                   input logic [KEY_W-1:0] exp_val);
        $display("ERROR at %0t: %s got %0h, wanted %0h", $time, what, got, exp_val);
        error_count++;
    endtask

    // Small keys near zero make neighbors and sign changes common in the pool.
    function automatic logic signed [KEY_W-1:0] KEY_KIND_SMALL(input int idx);
        return KEY_W'(idx - 8);
    endfunction

    // Applies one operation to the modeled store and returns the result it must give.
    function automatic set_result_t apply_set_op(input logic [1:0] code,
                                                 input logic signed [KEY_W-1:0] key);
        set_result_t r;
        int          pos;
        bit          hit;
        r = '0;
        pos = 0;
        while (pos < held_keys.size() && held_keys[pos] < key)
            pos++;
        hit = (pos < held_keys.size()) && (held_keys[pos] == key);
        case (code)
            OP_INSERT:
            begin
                // A duplicate is refused before capacity is looked at.
                if (!hit)
                begin
                    if (held_keys.size() >= SSE_CAPACITY)
                        r.full = 1'b1;
                    else
                    begin
                        held_keys.insert(pos, key);
                        r.ok = 1'b1;
                    end
                end
            end
            OP_REMOVE:
            begin
                if (hit)
                begin
                    held_keys.delete(pos);
                    r.ok = 1'b1;
                end
            end
            OP_LOOKUP:
                r.ok = hit;
            default:
                r.ok = 1'b0;
        endcase
        r.cnt = COUNT_W'(held_keys.size());
        return r;
    endfunction

    function automatic logic signed [KEY_W-1:0] pick_key(input bit from_held);
        int r;
        r = $urandom_range(99);
        if (from_held && held_keys.size() != 0 && r < 60)
            return held_keys[$urandom_range(held_keys.size() - 1)];
        r = $urandom_range(99);
        if (r < 70)
            return key_pool[$urandom_range(POOL_SIZE - 1)];
        if (r < 75)
        begin
            case ($urandom_range(4))
                0: return KEY_MIN;
                1: return KEY_MAX;
                2: return '0;
                3: return '1;
                default: return 64'sd1;
            endcase
        end
        return {$urandom, $urandom};
    endfunction

    // Drives one item, waits for it to be taken, then records what it must return.
    task automatic send_item(input logic [1:0] code, input logic signed [KEY_W-1:0] key,
                             input bit typed, input set_result_t typed_res);
        set_result_t pred;
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        op <= code;
        value <= key;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pred = apply_set_op(code, key);
        pending_results = {pending_results, (typed ? typed_res : pred)};
    endtask

    task automatic add_row(input logic [1:0] code, input logic signed [KEY_W-1:0] key,
                           input int typed, input int r_ok, input int r_full,
                           input int r_cnt);
        stim_row_t row;
        row.code = code;
        row.key = key;
        row.typed = (typed != 0);
        row.res.ok = (r_ok != 0);
        row.res.full = (r_full != 0);
        row.res.cnt = COUNT_W'(r_cnt);
        dir_rows = {dir_rows, row};
    endtask

    // Ends after the last result has been checked so the next drive falls in a fresh time step.
    task automatic drain_results();
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected response, count", KEY_W'(count), '0);
            else
            begin
                want = pending_results.pop_front();
                if (ok !== want.ok)
                    report_mismatch("ok", KEY_W'(ok), KEY_W'(want.ok));
                if (full_res !== want.full)
                    report_mismatch("full_res", KEY_W'(full_res), KEY_W'(want.full));
                if (count !== want.cnt)
                    report_mismatch("count", KEY_W'(count), KEY_W'(want.cnt));
            end
        end
        rsp_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end

    initial
    begin
        int          ins_pct;
        int          rem_pct;
        int          r;
        logic [1:0]  code;
        stim_row_t   row;

        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = (i < 16) ? KEY_KIND_SMALL(i) : {$urandom, $urandom};

        // Rows with typed results are the ones obvious from an empty store.
        add_row(OP_LOOKUP, '0, 1, 0, 0, 0);
        add_row(OP_REMOVE, 64'sd5, 1, 0, 0, 0);
        add_row(OP_NONE, '0, 1, 0, 0, 0);
        add_row(OP_INSERT, KEY_MIN, 1, 1, 0, 1);
        add_row(OP_INSERT, KEY_MAX, 1, 1, 0, 2);
        add_row(OP_INSERT, KEY_MIN, 1, 0, 0, 2);
        add_row(OP_LOOKUP, KEY_MIN, 1, 1, 0, 2);
        add_row(OP_LOOKUP, KEY_MAX, 1, 1, 0, 2);
        add_row(OP_INSERT, '0, 0, 0, 0, 0);
        add_row(OP_INSERT, '1, 0, 0, 0, 0);
        add_row(OP_INSERT, 64'sd1, 0, 0, 0, 0);
        add_row(OP_INSERT, 64'sh5555_5555_5555_5555, 0, 0, 0, 0);
        add_row(OP_INSERT, 64'shAAAA_AAAA_AAAA_AAAA, 0, 0, 0, 0);
        add_row(OP_LOOKUP, 64'sd2, 0, 0, 0, 0);
        add_row(OP_NONE, '1, 0, 0, 0, 0);
        add_row(OP_REMOVE, '0, 0, 0, 0, 0);
        add_row(OP_REMOVE, '0, 0, 0, 0, 0);
        add_row(OP_LOOKUP, 64'sd1, 0, 0, 0, 0);
        add_row(OP_REMOVE, KEY_MAX, 0, 0, 0, 0);
        add_row(OP_REMOVE, KEY_MIN, 0, 0, 0, 0);
        add_row(OP_LOOKUP, '1, 0, 0, 0, 0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            send_item(row.code, row.key, row.typed, row.res);
        end
        drain_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 64; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 64; end
                default: begin idle_pct = 37; stall_pct = 37; end
            endcase
            // First fill the store past capacity, then empty it again.
            for (int seg = 0; seg < 2; seg++)
            begin
                ins_pct = (seg == 0) ? 85 : 10;
                rem_pct = (seg == 0) ? 5 : 70;
                for (int n = 0; n < SEG_ITEMS; n++)
                begin
                    r = $urandom_range(99);
                    if (r < ins_pct)
                        code = OP_INSERT;
                    else if (r < ins_pct + rem_pct)
                        code = OP_REMOVE;
                    else if (r < 97)
                        code = OP_LOOKUP;
                    else
                        code = OP_NONE;
                    send_item(code, pick_key(code != OP_INSERT), 1'b0, '0);
                end
            end
            drain_results();
        end

        idle_pct = 0;
        stall_pct = 0;
        repeat (10) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
